>>> rtl/core/pipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipd_pkg
// Types and constants for the pulse interval to power and DAC code block.
// ----------------------------------------------------------------------------
package pipd_pkg;

   localparam int DAC_FULL_SCALE = 4095;
   localparam int POWER_BITS     = 24;

   localparam logic [63:0] ENERGY_NUMERATOR = 64'd360000000;

   localparam int STAMP_W    = 16;
   localparam int PPK_W      = 16;
   localparam int CW_W       = 16;
   localparam int PER_W      = 17;
   localparam int CSR_W      = 17;
   localparam int DAC_CODE_W = 12;
   localparam int POWER_W_W  = 24;

   localparam int DAC_W     = $clog2(DAC_FULL_SCALE + 1);
   localparam int DIFF_W    = 32;
   localparam int MUL_W     = PER_W;
   localparam int DEN_W     = PPK_W + MUL_W;
   localparam int MOD_STEPS = DIFF_W;
   localparam int MUL_STEPS = (MUL_W + 1) / 2;
   localparam int PROD_W    = POWER_BITS + DAC_W;
   localparam int LIM_W     = DAC_W + CW_W;
   localparam int CMP_W     = PROD_W + CW_W;
   localparam int CNT_W     = $clog2((POWER_BITS > MOD_STEPS) ? POWER_BITS : MOD_STEPS);

   typedef enum logic [1:0] {
      CSR_PULSES_PER_KWH = 2'd0,
      CSR_CONSUMER_WATTS = 2'd1,
      CSR_TIMER_PERIOD   = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_PULSE = 1'b0,
      FUNC_TICK  = 1'b1
   } func_type;

   typedef struct packed {
      logic                func;
      logic [STAMP_W-1:0]  timestamp;
      logic                enable;
   } req_type;

   typedef struct packed {
      logic [DAC_CODE_W-1:0] dac_code;
      logic [POWER_W_W-1:0]  power_w;
      logic                  saturated;
      logic                  refreshed;
   } rsp_type;

endpackage

>>> rtl/core/pulse_interval_power_to_dac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_interval_power_to_dac
// Meter pulse interval to power in watts and surplus-load DAC code.
// ----------------------------------------------------------------------------
// One event is taken at a time. A running meter pulse goes from the accepting
// edge to the result register through bit-serial modulo reduction of the
// 32-bit wrapped interval, a radix-4 serial multiply, a check state,
// restoring division over POWER_BITS (24) bits for the power, the setup
// states S_DSET and S_DCHK, restoring division over the DAC width (12) bits
// for the DAC code, and S_FIN, which loads the result. The power division is
// skipped when the power saturates and the DAC division when the code clamps
// or consumer watts is zero. Ticks and pulses with the switch off go straight
// to S_FIN. The next event is taken from the cycle after the result
// register is loaded, also while that result still waits on rsp_stall.
module pulse_interval_power_to_dac (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  pipd_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output pipd_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [1:0]                   csr_index,
   input  logic [pipd_pkg::CSR_W-1:0]   csr_wdata
);
   import pipd_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MOD  = 9'b000000010,
      S_MUL  = 9'b000000100,
      S_PCHK = 9'b000001000,
      S_PDIV = 9'b000010000,
      S_DSET = 9'b000100000,
      S_DCHK = 9'b001000000,
      S_DDIV = 9'b010000000,
      S_FIN  = 9'b100000000
   } state_type;

   localparam logic [DAC_W-1:0]      DAC_FS = DAC_W'(DAC_FULL_SCALE);
   localparam logic [DEN_W-1:0]      NUM_HI = DEN_W'(ENERGY_NUMERATOR >> POWER_BITS);
   localparam logic [POWER_BITS-1:0] NUM_LO = POWER_BITS'(ENERGY_NUMERATOR);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [PPK_W-1:0]         ppk_ff, ppk_in;
   logic [CW_W-1:0]          cw_ff, cw_in;
   logic [PER_W-1:0]         per_ff, per_in;
   logic [STAMP_W-1:0]       last_ff, last_in;
   logic                     seen_ff, seen_in;
   logic [DAC_CODE_W-1:0]    hdac_ff, hdac_in;
   logic [POWER_W_W-1:0]     hpow_ff, hpow_in;
   logic [PER_W-1:0]         mrem_ff, mrem_in;
   logic [DIFF_W-1:0]        mdvd_ff, mdvd_in;
   logic [MUL_W-1:0]         mplr_ff, mplr_in;
   logic [DEN_W-1:0]         mcand_ff, mcand_in;
   logic [DEN_W-1:0]         acc_ff, acc_in;
   logic [DEN_W-1:0]         prem_ff, prem_in;
   logic [POWER_BITS-1:0]    pdvd_ff, pdvd_in;
   logic [POWER_BITS-1:0]    pw_ff, pw_in;
   logic [PROD_W-1:0]        nprod_ff, nprod_in;
   logic [LIM_W-1:0]         lim_ff, lim_in;
   logic [CW_W-1:0]          drem_ff, drem_in;
   logic [DAC_W-1:0]         ddvd_ff, ddvd_in;
   logic [DAC_W-1:0]         dac_ff, dac_in;
   logic                     sat_ff, sat_in;
   logic                     refr_ff, refr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic [PER_W-1:0]         per_eff;
   logic [DIFF_W-1:0]        d_raw;
   logic [PER_W:0]           mtrial, mdiff;
   logic                     mfit;
   logic [PER_W-1:0]         mrem_step;
   logic [DEN_W-1:0]         mul_add;
   logic [DEN_W:0]           ptrial, pdiff;
   logic                     pfit;
   logic [CW_W:0]            dtrial, ddiff;
   logic                     dfit;
   logic [DAC_W-1:0]         dac_step;
   logic                     accept;

   assign accept  = req_valid && (state_ff == S_IDLE);
   assign per_eff = (per_ff == '0) ? PER_W'(1 << STAMP_W) : per_ff;
   assign d_raw   = (req_data.timestamp >= last_ff)
                  ? (DIFF_W'(req_data.timestamp) - DIFF_W'(last_ff))
                  : (DIFF_W'(req_data.timestamp) + DIFF_W'(per_eff) - DIFF_W'(last_ff));

   assign mtrial    = {mrem_ff, mdvd_ff[DIFF_W-1]};
   assign mfit      = mtrial >= {1'b0, per_eff};
   assign mdiff     = mtrial - {1'b0, per_eff};
   assign mrem_step = mfit ? mdiff[PER_W-1:0] : mtrial[PER_W-1:0];

   assign mul_add = (mplr_ff[0] ? mcand_ff : '0)
                  + (mplr_ff[1] ? {mcand_ff[DEN_W-2:0], 1'b0} : '0);

   assign ptrial = {prem_ff, pdvd_ff[POWER_BITS-1]};
   assign pfit   = ptrial >= {1'b0, acc_ff};
   assign pdiff  = ptrial - {1'b0, acc_ff};

   assign dtrial   = {drem_ff, ddvd_ff[DAC_W-1]};
   assign dfit     = dtrial >= {1'b0, cw_ff};
   assign ddiff    = dtrial - {1'b0, cw_ff};
   assign dac_step = {dac_ff[DAC_W-2:0], dfit};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ppk_in       = ppk_ff;
      cw_in        = cw_ff;
      per_in       = per_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      hdac_in      = hdac_ff;
      hpow_in      = hpow_ff;
      mrem_in      = mrem_ff;
      mdvd_in      = mdvd_ff;
      mplr_in      = mplr_ff;
      mcand_in     = mcand_ff;
      acc_in       = acc_ff;
      prem_in      = prem_ff;
      pdvd_in      = pdvd_ff;
      pw_in        = pw_ff;
      nprod_in     = nprod_ff;
      lim_in       = lim_ff;
      drem_in      = drem_ff;
      ddvd_in      = ddvd_ff;
      dac_in       = dac_ff;
      sat_in       = sat_ff;
      refr_in      = refr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_PULSES_PER_KWH: ppk_in = csr_wdata[PPK_W-1:0];
            CSR_CONSUMER_WATTS: cw_in  = csr_wdata[CW_W-1:0];
            CSR_TIMER_PERIOD:   per_in = csr_wdata[PER_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dac_in  = '0;
               pw_in   = '0;
               sat_in  = 1'b0;
               refr_in = 1'b0;
               state_in = S_FIN;
               if (req_data.func == FUNC_PULSE) begin
                  last_in = req_data.timestamp;
                  if (req_data.enable) begin
                     mrem_in  = '0;
                     mdvd_in  = d_raw;
                     cnt_in   = CNT_W'(MOD_STEPS - 1);
                     state_in = S_MOD;
                  end else begin
                     hdac_in = '0;
                     hpow_in = '0;
                  end
               end else begin
                  if (req_data.enable) begin
                     if (!seen_ff) begin
                        hdac_in = '0;
                        hpow_in = '0;
                        refr_in = 1'b1;
                     end else begin
                        dac_in = DAC_W'(hdac_ff);
                        pw_in  = POWER_BITS'(hpow_ff);
                     end
                  end else begin
                     hdac_in = '0;
                     hpow_in = '0;
                  end
                  seen_in = 1'b0;
               end
            end
         end
         S_MOD: begin
            mrem_in = mrem_step;
            mdvd_in = {mdvd_ff[DIFF_W-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               mplr_in  = mrem_step;
               mcand_in = DEN_W'(ppk_ff);
               acc_in   = '0;
               cnt_in   = CNT_W'(MUL_STEPS - 1);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            acc_in   = acc_ff + mul_add;
            mcand_in = {mcand_ff[DEN_W-3:0], 2'b00};
            mplr_in  = {2'b00, mplr_ff[MUL_W-1:2]};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (acc_ff <= NUM_HI) begin
               pw_in    = '1;
               sat_in   = 1'b1;
               state_in = S_DSET;
            end else begin
               prem_in  = NUM_HI;
               pdvd_in  = NUM_LO;
               pw_in    = '0;
               cnt_in   = CNT_W'(POWER_BITS - 1);
               state_in = S_PDIV;
            end
         end
         S_PDIV: begin
            prem_in = pfit ? pdiff[DEN_W-1:0] : ptrial[DEN_W-1:0];
            pdvd_in = {pdvd_ff[POWER_BITS-2:0], 1'b0};
            pw_in   = {pw_ff[POWER_BITS-2:0], pfit};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DSET;
            end
         end
         S_DSET: begin
            if (cw_ff == '0) begin
               dac_in   = DAC_FS;
               sat_in   = 1'b1;
               refr_in  = 1'b1;
               hdac_in  = DAC_CODE_W'(DAC_FS);
               hpow_in  = POWER_W_W'(pw_ff);
               seen_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               nprod_in = PROD_W'(DAC_FS) * PROD_W'(pw_ff);
               lim_in   = LIM_W'(DAC_FULL_SCALE + 1) * LIM_W'(cw_ff);
               state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            if (CMP_W'(nprod_ff) >= CMP_W'(lim_ff)) begin
               dac_in   = DAC_FS;
               refr_in  = 1'b1;
               hdac_in  = DAC_CODE_W'(DAC_FS);
               hpow_in  = POWER_W_W'(pw_ff);
               seen_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               drem_in  = CW_W'(nprod_ff >> DAC_W);
               ddvd_in  = nprod_ff[DAC_W-1:0];
               dac_in   = '0;
               cnt_in   = CNT_W'(DAC_W - 1);
               state_in = S_DDIV;
            end
         end
         S_DDIV: begin
            drem_in = dfit ? ddiff[CW_W-1:0] : dtrial[CW_W-1:0];
            ddvd_in = {ddvd_ff[DAC_W-2:0], 1'b0};
            dac_in  = dac_step;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               refr_in  = 1'b1;
               hdac_in  = DAC_CODE_W'(dac_step);
               hpow_in  = POWER_W_W'(pw_ff);
               seen_in  = 1'b1;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.dac_code  = DAC_CODE_W'(dac_ff);
               rsp_data_in.power_w   = POWER_W_W'(pw_ff);
               rsp_data_in.saturated = sat_ff;
               rsp_data_in.refreshed = refr_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ppk_ff       <= PPK_W'(1000);
         cw_ff        <= CW_W'(2000);
         per_ff       <= PER_W'(50000);
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         hdac_ff      <= '0;
         hpow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ppk_ff       <= ppk_in;
         cw_ff        <= cw_in;
         per_ff       <= per_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         hdac_ff      <= hdac_in;
         hpow_ff      <= hpow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mrem_ff     <= mrem_in;
      mdvd_ff     <= mdvd_in;
      mplr_ff     <= mplr_in;
      mcand_ff    <= mcand_in;
      acc_ff      <= acc_in;
      prem_ff     <= prem_in;
      pdvd_ff     <= pdvd_in;
      pw_ff       <= pw_in;
      nprod_ff    <= nprod_in;
      lim_ff      <= lim_in;
      drem_ff     <= drem_in;
      ddvd_ff     <= ddvd_in;
      dac_ff      <= dac_in;
      sat_ff      <= sat_in;
      refr_ff     <= refr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted beat did not make the block busy");

   a_sat_refr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.saturated || rsp_data.refreshed))
      else $error("saturated result without a refresh");

   a_mod_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> (mrem_ff < per_eff))
      else $error("modulo remainder out of range");

   a_pdiv_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PDIV) |-> (prem_ff < acc_ff))
      else $error("power divider remainder out of range");

   a_ddiv_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DDIV) |-> (drem_ff < cw_ff))
      else $error("DAC divider remainder out of range");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result loaded outside the finish state");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse interval to power and DAC code block.
// ----------------------------------------------------------------------------
// A queue of meter events feeds a valid/stall driver. Every accepted event
// goes through a bench-side predictor of interval, power, DAC code and held
// outputs, and each result beat is checked field by field against the
// oldest prediction. Register settings change between idle phases and cover
// zero divisors, the widest and narrowest timer periods and power clipping.
// Both sides idle at random, with one quiet phase in which the receiver
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;

   import pipd_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int HOLD_CYCLES = 600;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   req_type             event_q[$];
   rsp_type             meter_result_q[$];

   // predictor copy of registers and state
   int unsigned         cfg_ppk    = 1000;
   int unsigned         cfg_watts  = 2000;
   int unsigned         cfg_period = 50000;
   logic [STAMP_W-1:0]  prev_stamp = '0;
   logic                pulse_since_tick = 1'b0;
   logic [11:0]         hold_dac   = '0;
   logic [23:0]         hold_power = '0;

   logic                req_fire    = 1'b0;
   logic                quiet_mode  = 1'b0;
   logic                press_phase = 1'b0;
   logic                press_done  = 1'b0;
   int                  hold_left   = 0;
   int unsigned         walk_stamp  = 0;
   int                  cycle_count = 0;
   int                  mismatch_count = 0;
   int                  pulse_count = 0;
   int                  tick_count  = 0;
   int                  clip_count  = 0;
   int                  setting_count = 0;

   pulse_interval_power_to_dac dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type predict_meter_event(req_type ev);
      int unsigned     per;
      int unsigned     span;
      longint unsigned den;
      longint unsigned pw;
      longint unsigned pmax;
      longint unsigned q;
      rsp_type         r;
      r    = '0;
      pmax = (64'd1 << POWER_BITS) - 64'd1;
      if (ev.func == FUNC_PULSE) begin
         per = (cfg_period == 0) ? 32'd65536 : cfg_period;
         if (ev.timestamp >= prev_stamp)
            span = 32'(ev.timestamp) - 32'(prev_stamp);
         else
            span = 32'(ev.timestamp) + per - 32'(prev_stamp);
         span = span % per;
         prev_stamp = ev.timestamp;
         if (ev.enable) begin
            den = longint'(cfg_ppk) * longint'(span);
            if (den == 0) begin
               pw = pmax;
               r.saturated = 1'b1;
            end else begin
               pw = ENERGY_NUMERATOR / den;
               if (pw > pmax) begin
                  pw = pmax;
                  r.saturated = 1'b1;
               end
            end
            if (cfg_watts == 0) begin
               q = 64'(DAC_FULL_SCALE);
               r.saturated = 1'b1;
            end else begin
               q = (longint'(DAC_FULL_SCALE) * pw) / cfg_watts;
               if (q > DAC_FULL_SCALE) q = 64'(DAC_FULL_SCALE);
            end
            r.dac_code  = q[11:0];
            r.power_w   = pw[23:0];
            r.refreshed = 1'b1;
            hold_dac    = q[11:0];
            hold_power  = pw[23:0];
            pulse_since_tick = 1'b1;
         end else begin
            hold_dac   = '0;
            hold_power = '0;
         end
      end else begin
         if (ev.enable) begin
            if (!pulse_since_tick) begin
               hold_dac    = '0;
               hold_power  = '0;
               r.refreshed = 1'b1;
            end
            r.dac_code = hold_dac;
            r.power_w  = hold_power;
         end else begin
            hold_dac   = '0;
            hold_power = '0;
         end
         pulse_since_tick = 1'b0;
      end
      return r;
   endfunction

   // request driver: hold a stalled beat, else idle or advance
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (event_q.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 35)) begin
            req_data  <= event_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall driver, with one long hold-off in the pressure phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (press_phase && !press_done) begin
         rsp_stall  <= 1'b1;
         press_done <= 1'b1;
         hold_left  <= HOLD_CYCLES;
      end else begin
         rsp_stall <= !quiet_mode && ($urandom_range(0, 99) < 35);
      end
   end

   // monitor: check result beats, then predict accepted request beats
   always @(posedge clock) begin
      rsp_type want;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (meter_result_q.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = meter_result_q.pop_front();
            if (rsp_data.dac_code !== want.dac_code) begin
               $display("%0t: dac_code expected %0d actual %0d",
                        $time, want.dac_code, rsp_data.dac_code);
               mismatch_count++;
            end
            if (rsp_data.power_w !== want.power_w) begin
               $display("%0t: power_w expected %0d actual %0d",
                        $time, want.power_w, rsp_data.power_w);
               mismatch_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $display("%0t: saturated expected %0b actual %0b",
                        $time, want.saturated, rsp_data.saturated);
               mismatch_count++;
            end
            if (rsp_data.refreshed !== want.refreshed) begin
               $display("%0t: refreshed expected %0b actual %0b",
                        $time, want.refreshed, rsp_data.refreshed);
               mismatch_count++;
            end
            if (want.saturated) clip_count++;
         end
      end
      if (!reset && req_valid && !req_stall) begin
         meter_result_q.push_back(predict_meter_event(req_data));
         if (req_data.func == FUNC_PULSE) pulse_count++;
         else tick_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d results outstanding",
                  $time, meter_result_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic queue_event(logic is_tick, logic [STAMP_W-1:0] ts, logic en);
      req_type ev;
      ev.func      = is_tick ? FUNC_TICK : FUNC_PULSE;
      ev.timestamp = ts;
      ev.enable    = en;
      event_q.push_back(ev);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PULSES_PER_KWH: cfg_ppk    = 32'(val[PPK_W-1:0]);
         CSR_CONSUMER_WATTS: cfg_watts  = 32'(val[CW_W-1:0]);
         CSR_TIMER_PERIOD:   cfg_period = 32'(val);
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (event_q.size() > 0 || req_valid || meter_result_q.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // mostly well-formed pulse trains and ticks, the rest noise
   task automatic queue_random_events(int count);
      int unsigned per;
      int unsigned step;
      int unsigned pick;
      int unsigned sel;
      per = (cfg_period == 0) ? 32'd65536 : cfg_period;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            queue_event(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)));
         end else if (pick < 45) begin
            queue_event(FUNC_TICK, 16'($urandom_range(0, 65535)),
                        $urandom_range(0, 19) != 0);
         end else begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
               step = $urandom_range(0, 25);
            else if (sel < 7)
               step = $urandom_range(1, 4000);
            else
               step = $urandom_range(1, per);
            walk_stamp = (walk_stamp + step) % per;
            queue_event(FUNC_PULSE, walk_stamp[STAMP_W-1:0], $urandom_range(0, 19) != 0);
         end
      end
   endtask

   task automatic run_phase(int unsigned ppk, int unsigned watts, int unsigned period,
                            int count);
      write_csr(CSR_PULSES_PER_KWH, CSR_W'(ppk));
      write_csr(CSR_CONSUMER_WATTS, CSR_W'(watts));
      write_csr(CSR_TIMER_PERIOD, CSR_W'(period));
      setting_count++;
      queue_random_events(count);
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero interval, wrap, ticks with and without pulses, switch off
      setting_count = 1;
      queue_event(FUNC_PULSE, 16'd0, 1'b1);
      queue_event(FUNC_PULSE, 16'd36000, 1'b1);
      queue_event(FUNC_TICK, 16'hFFFF, 1'b1);
      queue_event(FUNC_TICK, 16'd0, 1'b1);
      queue_event(FUNC_PULSE, 16'hFFFF, 1'b1);
      queue_event(FUNC_PULSE, 16'd100, 1'b1);
      queue_event(FUNC_PULSE, 16'd100, 1'b1);
      queue_event(FUNC_PULSE, 16'd200, 1'b0);
      queue_event(FUNC_TICK, 16'd0, 1'b0);
      queue_event(FUNC_PULSE, 16'd201, 1'b1);
      queue_event(FUNC_PULSE, 16'd1201, 1'b1);
      queue_event(FUNC_TICK, 16'd5, 1'b1);
      queue_event(FUNC_TICK, 16'd5, 1'b1);
      queue_event(FUNC_PULSE, 16'hFFFF, 1'b1);
      queue_event(FUNC_PULSE, 16'd0, 1'b1);
      queue_event(FUNC_PULSE, 16'd1, 1'b1);
      queue_event(FUNC_PULSE, 16'hAAAA, 1'b1);
      queue_event(FUNC_PULSE, 16'h5555, 1'b1);
      queue_event(FUNC_PULSE, 16'hFFFF, 1'b0);
      queue_event(FUNC_TICK, 16'hFFFF, 1'b1);
      queue_event(FUNC_TICK, 16'd0, 1'b1);
      queue_event(FUNC_PULSE, 16'd49999, 1'b1);
      wait_idle();

      run_phase(1000, 2000, 50000, 93);
      run_phase(0, 2000, 50000, 93);
      quiet_mode  = 1'b1;
      press_phase = 1'b1;
      run_phase(65535, 65535, 65536, 93);
      quiet_mode  = 1'b0;
      press_phase = 1'b0;
      run_phase(1, 1, 1, 93);
      run_phase(65535, 0, 0, 93);
      run_phase(3600, 3000, 1000, 93);
      run_phase(1, 65535, 65536, 93);
      run_phase($urandom_range(1, 20), $urandom_range(1, 65535), $urandom_range(1, 65536), 93);
      run_phase($urandom_range(1, 65535), $urandom_range(1, 65535),
                $urandom_range(1, 65536), 93);
      run_phase($urandom_range(1, 65535), $urandom_range(1, 5000),
                $urandom_range(1, 65536), 93);

      repeat (100) @(posedge clock);
      if (meter_result_q.size() > 0)
         $display("%0t: %0d expected results never arrived", $time, meter_result_q.size());
      $display("Covered %0d meter events (%0d pulses, %0d ticks) over %0d register settings,",
               pulse_count + tick_count, pulse_count, tick_count, setting_count);
      $display("with %0d saturated or clipped results and %0d mismatches.",
               clip_count, mismatch_count);
      if (mismatch_count == 0 && meter_result_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
